[rtl/lmr_pkg.sv]
// Shared types and constants of the line message ring FIFO.
`timescale 1ns / 1ps
package lmr_pkg;

  localparam int RING_BYTES = 4096;
  localparam int RING_AW    = $clog2(RING_BYTES);
  localparam int MAX_READ   = 64;
  localparam int LEN_SAT    = 4095;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  // input kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // result status codes
  localparam logic [2:0] ST_BYTE     = 3'd0;
  localparam logic [2:0] ST_NO_MSG   = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_ACCEPT   = 3'd3;
  localparam logic [2:0] ST_REJECT   = 3'd4;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_NEWLINE = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [6:0] cap;
  } cmd_t;

  typedef struct packed {
    logic [RING_AW:0] free_space;
    logic [RING_AW:0] msg_count;
  } mon_t;

  function automatic logic [11:0] sat_len(input logic [RING_AW:0] n);
    if (32'(n) > LEN_SAT) return 12'(LEN_SAT);
    else return 12'(n);
  endfunction

endpackage

[rtl/line_message_ring_fifo_unit.sv]
// Top level of the line message ring FIFO.
`timescale 1ns / 1ps
// Stores newline-terminated messages in a 4096-byte ring.
// Input words: tuser = kind (0 push byte, 1 read message). A push word
// carries one byte; a newline byte commits the staged message if it is
// shorter than the free space, and returns one word with status accepted
// or rejected. A read word returns no-message, too-long, or the first
// message one byte per word, tlast on the final one.
// A push or a no-message read is handled from the idle state; a read of a
// stored message goes through a length lookup state, and a delivered
// message then alternates fetch and send states per byte, since the ring
// RAM's registered read port sets the per-byte pace. A two-word command
// queue sits in front, and results leave through a one-word output
// register, so byte pushes keep flowing while a result waits.
// Reset empties the ring, the length queue and the staging; results are
// held while out_tready is low, and commands that need the output stall until it is taken.
module line_message_ring_fifo_unit import lmr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // kind
  input  logic [15:0] in_tdata,   // data_byte[7:0], reader_capacity[14:8], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // status
  output logic [23:0] out_tdata,  // out_byte[7:0], message_length[19:8], zero pad
  output logic        out_tlast
);

  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;
  mon_t       mon;
  logic [7:0] o_byte;
  logic [11:0] o_len;

  lmr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  lmr_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_status(out_tuser),
    .out_byte(o_byte), .out_len(o_len), .out_last(out_tlast), .mon(mon)
  );

  assign out_tdata = {4'b0, o_len, o_byte};

  a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
    (mon.msg_count == '0) == (32'(mon.free_space) == RING_BYTES))
    else $error("message count and free space disagree");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(mon.free_space) <= RING_BYTES)
    else $error("free space above ring size");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_BYTE) |-> out_tlast)
    else $error("single-word result without tlast");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

endmodule

[rtl/lmr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lmr_front.sv]
// Input side: accepts words, classifies them and queues commands.
`timescale 1ns / 1ps
module lmr_front import lmr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,
  input  logic [15:0] in_tdata,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  cmd_t       cls;
  logic       push;

  always_comb begin
    cls.data = in_tdata[7:0];
    cls.cap  = (in_tdata[14:8] > 7'(MAX_READ)) ? 7'(MAX_READ) : in_tdata[14:8];
    if (in_tuser == KIND_READ) cls.op = OP_READ;
    else if (in_tdata[7:0] == NEWLINE_BYTE) cls.op = OP_NEWLINE;
    else cls.op = OP_BYTE;
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

[rtl/lmr_back.sv]
// Execution side: ring storage, message length queue and result register.
`timescale 1ns / 1ps
module lmr_back import lmr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_byte,
  output logic [11:0] out_len,
  output logic        out_last,
  output mon_t        mon
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_FETCH = 4'b0100,
    S_SEND  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [RING_AW-1:0] rd_ptr_r, rd_ptr_nxt, commit_r, commit_nxt;
  logic [RING_AW:0]   stage_r, stage_nxt, free_r, free_nxt, msgs_r, msgs_nxt;
  logic               ovf_r, ovf_nxt;
  logic [RING_AW-1:0] len_wr_r, len_wr_nxt, len_rd_r, len_rd_nxt;
  logic [RING_AW-1:0] len_r, len_nxt, cnt_r, cnt_nxt;
  logic [6:0]         cap_r, cap_nxt;

  logic               ov_r, ov_nxt, olast_r, olast_nxt;
  logic [2:0]         ost_r, ost_nxt;
  logic [7:0]         obyte_r, obyte_nxt;
  logic [11:0]        olen_r, olen_nxt;

  logic               ring_we, ring_re, lq_we, lq_re;
  logic [RING_AW-1:0] ring_waddr;
  logic [7:0]         ring_rdata;
  logic [RING_AW-1:0] lq_rdata;
  logic [RING_AW:0]   nl_len;
  logic               out_free, nl_ok;

  lmr_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(cmd.data),
    .re(ring_re), .raddr(rd_ptr_r), .rdata(ring_rdata)
  );

  lmr_ram #(.WIDTH(RING_AW), .DEPTH(RING_BYTES)) u_lenq (
    .clk(clk), .we(lq_we), .waddr(len_wr_r), .wdata(nl_len[RING_AW-1:0]),
    .re(lq_re), .raddr(len_rd_r), .rdata(lq_rdata)
  );

  assign out_free   = !ov_r || out_tready;
  assign ring_waddr = commit_r + stage_r[RING_AW-1:0];
  assign nl_len     = stage_r + 1'b1;
  assign nl_ok      = !ovf_r && (nl_len < free_r);

  always_comb begin
    state_nxt  = state_r;
    rd_ptr_nxt = rd_ptr_r;  commit_nxt = commit_r;
    stage_nxt  = stage_r;   free_nxt   = free_r;   msgs_nxt = msgs_r;
    ovf_nxt    = ovf_r;     len_wr_nxt = len_wr_r; len_rd_nxt = len_rd_r;
    len_nxt    = len_r;     cnt_nxt    = cnt_r;    cap_nxt  = cap_r;
    ov_nxt     = ov_r && !out_tready;
    ost_nxt    = ost_r;     obyte_nxt  = obyte_r;
    olen_nxt   = olen_r;    olast_nxt  = olast_r;
    cmd_pop = 1'b0;
    ring_we = 1'b0; ring_re = 1'b0; lq_we = 1'b0; lq_re = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_BYTE: begin
              cmd_pop = 1'b1;
              ring_we = (stage_r < free_r);
              if (32'(stage_r) < RING_BYTES) stage_nxt = stage_r + 1'b1;
              else ovf_nxt = 1'b1;
            end
            OP_NEWLINE: begin
              if (out_free) begin
                cmd_pop = 1'b1;
                if (nl_ok) begin
                  ring_we    = 1'b1;
                  lq_we      = 1'b1;
                  len_wr_nxt = len_wr_r + 1'b1;
                  msgs_nxt   = msgs_r + 1'b1;
                  commit_nxt = commit_r + nl_len[RING_AW-1:0];
                  free_nxt   = free_r - nl_len;
                end
                stage_nxt = '0;
                ovf_nxt   = 1'b0;
                ov_nxt    = 1'b1;
                ost_nxt   = nl_ok ? ST_ACCEPT : ST_REJECT;
                obyte_nxt = '0;
                olen_nxt  = sat_len(nl_len);
                olast_nxt = 1'b1;
              end
            end
            OP_READ: begin
              if (msgs_r != '0) begin
                cmd_pop   = 1'b1;
                lq_re     = 1'b1;
                cap_nxt   = cmd.cap;
                state_nxt = S_LOOK;
              end else if (out_free) begin
                cmd_pop   = 1'b1;
                ov_nxt    = 1'b1;
                ost_nxt   = ST_NO_MSG;
                obyte_nxt = '0;
                olen_nxt  = '0;
                olast_nxt = 1'b1;
              end
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      S_LOOK: begin
        len_nxt = lq_rdata;
        cnt_nxt = '0;
        if (32'(lq_rdata) > 32'(cap_r)) begin
          // report the length, keep the message in place
          if (out_free) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_TOO_LONG;
            obyte_nxt = '0;
            olen_nxt  = sat_len({1'b0, lq_rdata});
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        ring_re   = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          ost_nxt    = ST_BYTE;
          obyte_nxt  = ring_rdata;
          olen_nxt   = sat_len({1'b0, len_r});
          olast_nxt  = (cnt_r + 1'b1 == len_r);
          rd_ptr_nxt = rd_ptr_r + 1'b1;
          if (cnt_r + 1'b1 == len_r) begin
            free_nxt   = free_r + {1'b0, len_r};
            msgs_nxt   = msgs_r - 1'b1;
            len_rd_nxt = len_rd_r + 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_FETCH;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    cnt_r   <= cnt_nxt;
    cap_r   <= cap_nxt;
    ost_r   <= ost_nxt;
    obyte_r <= obyte_nxt;
    olen_r  <= olen_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_ptr_r <= '0;
      commit_r <= '0;
      stage_r  <= '0;
      free_r   <= (RING_AW+1)'(RING_BYTES);
      msgs_r   <= '0;
      ovf_r    <= 1'b0;
      len_wr_r <= '0;
      len_rd_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      commit_r <= commit_nxt;
      stage_r  <= stage_nxt;
      free_r   <= free_nxt;
      msgs_r   <= msgs_nxt;
      ovf_r    <= ovf_nxt;
      len_wr_r <= len_wr_nxt;
      len_rd_r <= len_rd_nxt;
      ov_r     <= ov_nxt;
    end
  end

  assign out_tvalid     = ov_r;
  assign out_status     = ost_r;
  assign out_byte       = obyte_r;
  assign out_len        = olen_r;
  assign out_last       = olast_r;
  assign mon.free_space = free_r;
  assign mon.msg_count  = msgs_r;

endmodule
